/* rtl/ldrs_pkg.sv */
// package for the look disk request scheduler: widths, defaults, codes, sequencer states
// no dependencies
`timescale 1ns / 1ps

package ldrs_pkg;

  localparam int MAX_REQUESTS_DEF = 32;

  localparam int CYL_W  = 16;
  localparam int MOVE_W = 23;   // running travel kept internally
  localparam int OUT_MOVE_W = 22;
  localparam int OUT_TDATA_W = 40;

  // input command codes
  localparam logic CMD_LOAD  = 1'b0;
  localparam logic CMD_START = 1'b1;

  // configuration register indexes
  localparam logic REG_HEAD_START = 1'b0;
  localparam logic REG_SWEEP_UP   = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_INS_RD,
    ST_INS_CMP,
    ST_SCAN_RD,
    ST_SCAN_CMP,
    ST_SRV_RD,
    ST_SRV_CALC,
    ST_EMPTY
  } ldrs_state_t;

endpackage

/* rtl/ldrs_ram.sv */
// generic single write port, single read port ram with registered read data
// no dependencies
`timescale 1ns / 1ps

module ldrs_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 32,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* rtl/look_disk_request_scheduler_core.sv */
// look disk request scheduler: insertion sort into a ram on load, look order serving on start
// depends on ldrs_pkg and ldrs_ram
// load: the new cylinder is inserted by reading stored entries from the top down and shifting
//   every entry greater than it up one slot; start: entries are scanned for the split, then served
//   in look order, stalling on out_tready; an empty start gives one result; reset sets sweep up
// one request at a time, in_tready low meanwhile; sync reset clears count, travel, head, head start
`timescale 1ns / 1ps

module look_disk_request_scheduler_core
  import ldrs_pkg::*;
#(
  parameter int MAX_REQUESTS = MAX_REQUESTS_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  // input stream
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic [CYL_W-1:0]       in_tdata,   // [15:0] cylinder
  input  logic                   in_tuser,   // [0] command
  // result stream
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [OUT_TDATA_W-1:0] out_tdata,  // [15:0] served_cylinder, [37:16] total_movement
  output logic                   out_tlast,
  // configuration
  input  logic                   cfg_we,
  input  logic                   cfg_index,
  input  logic [CYL_W-1:0]       cfg_wdata
);

  localparam int AW = (MAX_REQUESTS > 1) ? $clog2(MAX_REQUESTS) : 1;
  localparam int CW = $clog2(MAX_REQUESTS + 1);

  ldrs_state_t state_r, state_nxt;

  logic [CW-1:0]     cnt_r, cnt_nxt;
  logic [CYL_W-1:0]  key_r, key_nxt;
  logic [AW-1:0]     b_r, b_nxt;
  logic [AW-1:0]     ptr_r, ptr_nxt;
  logic              up_r, up_nxt;
  logic [CW-1:0]     split_r, split_nxt;
  logic [CW-1:0]     k_r, k_nxt;
  logic [CYL_W-1:0]  head_now_r, head_now_nxt;
  logic [MOVE_W-1:0] move_r, move_nxt;
  logic [CYL_W-1:0]  head_start_r;
  logic              sweep_up_r;

  logic                  out_valid_r, out_valid_nxt;
  logic [CYL_W-1:0]      out_cyl_r, out_cyl_nxt;
  logic [OUT_MOVE_W-1:0] out_move_r, out_move_nxt;
  logic                  out_last_r, out_last_nxt;

  logic              ram_we;
  logic [AW-1:0]     ram_waddr, ram_raddr;
  logic [CYL_W-1:0]  ram_wdata, ram_rdata;

  logic              out_free;
  logic [CW-1:0]     ptr_inc;
  logic [CW-1:0]     scan_split;
  logic [CW-1:0]     split_dec;
  logic [CYL_W-1:0]  seek_gap;
  logic              found;

  ldrs_ram #(
    .WIDTH (CYL_W),
    .DEPTH (MAX_REQUESTS),
    .AW    (AW)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign in_tready  = (state_r == ST_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{(OUT_TDATA_W - OUT_MOVE_W - CYL_W){1'b0}}, out_move_r, out_cyl_r};
  assign out_tlast  = out_last_r;

  assign out_free   = !out_valid_r || out_tready;
  assign ptr_inc    = CW'(ptr_r) + CW'(1);
  assign found      = (ram_rdata > head_start_r);
  assign seek_gap   = (ram_rdata >= head_now_r) ? (ram_rdata - head_now_r)
                                                : (head_now_r - ram_rdata);
  assign scan_split = found ? CW'(ptr_r) : cnt_r;
  // split of the current scan step, or the stored split while serving
  assign split_dec  = ((state_r == ST_SCAN_CMP) ? scan_split : split_r) - CW'(1);

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_start_r <= '0;
      sweep_up_r   <= 1'b1;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_HEAD_START: head_start_r <= cfg_wdata;
        REG_SWEEP_UP:   sweep_up_r   <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= '0;
      k_r         <= '0;
      head_now_r  <= '0;
      move_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      k_r         <= k_nxt;
      head_now_r  <= head_now_nxt;
      move_r      <= move_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    key_r      <= key_nxt;
    b_r        <= b_nxt;
    ptr_r      <= ptr_nxt;
    up_r       <= up_nxt;
    split_r    <= split_nxt;
    out_cyl_r  <= out_cyl_nxt;
    out_move_r <= out_move_nxt;
    out_last_r <= out_last_nxt;
  end

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    key_nxt       = key_r;
    b_nxt         = b_r;
    ptr_nxt       = ptr_r;
    up_nxt        = up_r;
    split_nxt     = split_r;
    k_nxt         = k_r;
    head_now_nxt  = head_now_r;
    move_nxt      = move_r;
    out_valid_nxt = out_valid_r && !out_tready;
    out_cyl_nxt   = out_cyl_r;
    out_move_nxt  = out_move_r;
    out_last_nxt  = out_last_r;
    ram_we        = 1'b0;
    ram_waddr     = b_r;
    ram_wdata     = key_r;
    ram_raddr     = ptr_r;

    unique case (state_r)
      ST_IDLE: begin
        if (in_tvalid) begin
          if (in_tuser == CMD_LOAD) begin
            // full store drops the request
            if (cnt_r != CW'(MAX_REQUESTS)) begin
              key_nxt   = in_tdata;
              b_nxt     = cnt_r[AW-1:0];
              state_nxt = ST_INS_RD;
            end
          end else begin
            head_now_nxt = head_start_r;
            move_nxt     = '0;
            k_nxt        = '0;
            ptr_nxt      = '0;
            state_nxt    = (cnt_r == '0) ? ST_EMPTY : ST_SCAN_RD;
          end
        end
      end

      ST_INS_RD: begin
        ram_raddr = b_r - AW'(1);
        if (b_r == '0) begin
          ram_we    = 1'b1;
          cnt_nxt   = cnt_r + CW'(1);
          state_nxt = ST_IDLE;
        end else begin
          state_nxt = ST_INS_CMP;
        end
      end

      ST_INS_CMP: begin
        ram_raddr = b_r - AW'(1);
        ram_we    = 1'b1;
        if (ram_rdata > key_r) begin
          // shift the larger entry up one slot
          ram_wdata = ram_rdata;
          b_nxt     = b_r - AW'(1);
          state_nxt = ST_INS_RD;
        end else begin
          cnt_nxt   = cnt_r + CW'(1);
          state_nxt = ST_IDLE;
        end
      end

      ST_SCAN_RD: begin
        state_nxt = ST_SCAN_CMP;
      end

      ST_SCAN_CMP: begin
        if (found || ptr_inc == cnt_r) begin
          split_nxt = scan_split;
          if (sweep_up_r) begin
            up_nxt  = (split_nxt != cnt_r);
            ptr_nxt = (split_nxt != cnt_r) ? split_nxt[AW-1:0] : split_dec[AW-1:0];
          end else begin
            up_nxt  = (split_nxt == '0);
            ptr_nxt = (split_nxt == '0) ? '0 : split_dec[AW-1:0];
          end
          state_nxt = ST_SRV_RD;
        end else begin
          ptr_nxt   = ptr_inc[AW-1:0];
          state_nxt = ST_SCAN_RD;
        end
      end

      ST_SRV_RD: begin
        state_nxt = ST_SRV_CALC;
      end

      ST_SRV_CALC: begin
        if (out_free) begin
          move_nxt      = move_r + MOVE_W'(seek_gap);
          head_now_nxt  = ram_rdata;
          out_valid_nxt = 1'b1;
          out_cyl_nxt   = ram_rdata;
          out_move_nxt  = move_nxt[OUT_MOVE_W-1:0];
          out_last_nxt  = (k_r + CW'(1) == cnt_r);
          if (out_last_nxt) begin
            cnt_nxt   = '0;
            state_nxt = ST_IDLE;
          end else begin
            k_nxt     = k_r + CW'(1);
            state_nxt = ST_SRV_RD;
            // at the end of the first sweep turn around at the split
            if (up_r) begin
              if (ptr_inc == cnt_r) begin
                up_nxt  = 1'b0;
                ptr_nxt = split_dec[AW-1:0];
              end else begin
                ptr_nxt = ptr_inc[AW-1:0];
              end
            end else begin
              if (ptr_r == '0) begin
                up_nxt  = 1'b1;
                ptr_nxt = split_r[AW-1:0];
              end else begin
                ptr_nxt = ptr_r - AW'(1);
              end
            end
          end
        end
      end

      ST_EMPTY: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_cyl_nxt   = head_start_r;
          out_move_nxt  = '0;
          out_last_nxt  = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // store never holds more than its capacity
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CW'(MAX_REQUESTS))
    else $error("request count beyond capacity");

  // insertion slot stays at most one past the filled part of the store
  a_ins_slot: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_INS_RD || state_r == ST_INS_CMP) |-> CW'(b_r) < cnt_r + CW'(1))
    else $error("insertion slot past request count");

  // split scan and serving only touch stored entries
  a_ptr_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SCAN_CMP || state_r == ST_SRV_CALC) |-> CW'(ptr_r) < cnt_r)
    else $error("read pointer past request count");

  // a run emits no more results than stored requests
  a_k_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SRV_RD || state_r == ST_SRV_CALC) |-> k_r < cnt_r)
    else $error("served count past request count");

endmodule
